### sv/rtc_pkg.sv
`default_nettype none
package rtc_pkg;

  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } xform_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQUARE,
    N_SUM,
    N_ROOT,
    N_PREP,
    N_DIV,
    N_DONE
  } norm_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_POINT
  } top_state_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_POINT = 1'b1;

endpackage
`default_nettype wire

### sv/rtc_norm.sv
`default_nettype none
module rtc_norm (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire signed [31:0]  dir_x,
  input  wire signed [31:0]  dir_y,
  output logic               done,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy
);

  rtc_pkg::norm_state_t state, state_next;

  logic [31:0] ax, ay;
  logic        negx, negy;
  logic [63:0] sqx, sqy, v;
  logic [35:0] sqrt_rem;
  logic [31:0] root;
  logic [5:0]  cnt;
  logic [31:0] s;
  logic [61:0] numx, numy;
  logic [31:0] remx, remy;
  logic [30:0] qx, qy;

  logic [35:0] rem_t, trial;
  logic [32:0] rx_t, ry_t;

  always_comb begin
    rem_t = {sqrt_rem[33:0], v[63:62]};
    trial = {2'b00, root, 2'b01};
    rx_t  = {remx, numx[61]};
    ry_t  = {remy, numy[61]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtc_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    ux         = negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    uy         = negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    case (state)
      rtc_pkg::N_IDLE: begin
        if (start) begin
          if (dir_x == 32'sd0 && dir_y == 32'sd0) begin
            state_next = rtc_pkg::N_DONE;
          end else begin
            state_next = rtc_pkg::N_SHIFT;
          end
        end
      end
      rtc_pkg::N_SHIFT: begin
        if (ax[31:30] != 2'b00 || ay[31:30] != 2'b00) begin
          state_next = rtc_pkg::N_SQUARE;
        end
      end
      rtc_pkg::N_SQUARE: state_next = rtc_pkg::N_SUM;
      rtc_pkg::N_SUM:    state_next = rtc_pkg::N_ROOT;
      rtc_pkg::N_ROOT: begin
        if (cnt == 6'd31) begin
          state_next = rtc_pkg::N_PREP;
        end
      end
      rtc_pkg::N_PREP: state_next = rtc_pkg::N_DIV;
      rtc_pkg::N_DIV: begin
        if (cnt == 6'd61) begin
          state_next = rtc_pkg::N_DONE;
        end
      end
      rtc_pkg::N_DONE: begin
        done       = 1'b1;
        state_next = rtc_pkg::N_IDLE;
      end
      default: state_next = rtc_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rtc_pkg::N_IDLE: begin
        ax   <= dir_x[31] ? 32'(-dir_x) : 32'(dir_x);
        ay   <= dir_y[31] ? 32'(-dir_y) : 32'(dir_y);
        negx <= dir_x[31];
        negy <= dir_y[31];
        qx   <= '0;
        qy   <= '0;
      end
      rtc_pkg::N_SHIFT: begin
        if (ax[31:30] == 2'b00 && ay[31:30] == 2'b00) begin
          ax <= {ax[30:0], 1'b0};
          ay <= {ay[30:0], 1'b0};
        end
      end
      rtc_pkg::N_SQUARE: begin
        sqx <= ax * ax;
        sqy <= ay * ay;
      end
      rtc_pkg::N_SUM: begin
        v        <= sqx + sqy;
        sqrt_rem <= '0;
        root     <= '0;
        cnt      <= '0;
      end
      rtc_pkg::N_ROOT: begin
        if (rem_t >= trial) begin
          sqrt_rem <= rem_t - trial;
          root     <= {root[30:0], 1'b1};
        end else begin
          sqrt_rem <= rem_t;
          root     <= {root[30:0], 1'b0};
        end
        v   <= {v[61:0], 2'b00};
        cnt <= cnt + 6'd1;
      end
      rtc_pkg::N_PREP: begin
        s    <= root;
        numx <= {ax, 30'd0} + 62'(root >> 1);
        numy <= {ay, 30'd0} + 62'(root >> 1);
        remx <= '0;
        remy <= '0;
        cnt  <= '0;
      end
      rtc_pkg::N_DIV: begin
        if (rx_t >= {1'b0, s}) begin
          remx <= 32'(rx_t - {1'b0, s});
          qx   <= {qx[29:0], 1'b1};
        end else begin
          remx <= rx_t[31:0];
          qx   <= {qx[29:0], 1'b0};
        end
        if (ry_t >= {1'b0, s}) begin
          remy <= 32'(ry_t - {1'b0, s});
          qy   <= {qy[29:0], 1'b1};
        end else begin
          remy <= ry_t[31:0];
          qy   <= {qy[29:0], 1'b0};
        end
        numx <= {numx[60:0], 1'b0};
        numy <= {numy[60:0], 1'b0};
        cnt  <= cnt + 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/rtc_cell.sv
`default_nettype none
module rtc_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  en,
  input  wire                  we,
  input  wire rtc_pkg::xform_t wdata,
  input  wire                  apply,
  input  wire rtc_pkg::pt_t    pin,
  output rtc_pkg::pt_t         pout
);

  rtc_pkg::xform_t    xf;
  logic               valid_a, apply_a;
  logic signed [31:0] px, py;
  logic signed [63:0] p_xx, p_yy, p_yx, p_xy;

  logic signed [64:0] sx, sy;
  logic signed [34:0] rx, ry;
  logic signed [35:0] nx, ny;
  logic signed [31:0] fx, fy;

  // rotated sums, rounded half up to q16.16, then translated and saturated
  always_comb begin
    sx = 65'(p_xx) - 65'(p_yy);
    sy = 65'(p_yx) + 65'(p_xy);
    rx = 35'((sx + 65'sd536870912) >>> 30);
    ry = 35'((sy + 65'sd536870912) >>> 30);
    nx = 36'(rx) + 36'(xf.tx);
    ny = 36'(ry) + 36'(xf.ty);
    if (nx > 36'sd2147483647) begin
      fx = 32'sh7fffffff;
    end else if (nx < -36'sd2147483648) begin
      fx = 32'sh80000000;
    end else begin
      fx = nx[31:0];
    end
    if (ny > 36'sd2147483647) begin
      fy = 32'sh7fffffff;
    end else if (ny < -36'sd2147483648) begin
      fy = 32'sh80000000;
    end else begin
      fy = ny[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      xf <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a    <= 1'b0;
      pout.valid <= 1'b0;
    end else if (en) begin
      valid_a    <= pin.valid;
      pout.valid <= valid_a;
    end
    if (en) begin
      apply_a <= apply;
      px      <= pin.x;
      py      <= pin.y;
      p_xx    <= xf.ux * pin.x;
      p_yy    <= xf.uy * pin.y;
      p_yx    <= xf.uy * pin.x;
      p_xy    <= xf.ux * pin.y;
      pout.x  <= apply_a ? fx : px;
      pout.y  <= apply_a ? fy : py;
    end
  end

endmodule
`default_nettype wire

### sv/rigid_transform_chain_core.sv
`default_nettype none
// Chained 2D rigid transforms on q16.16 points. A load word normalises its
// direction in an iterative unit (shift, 32-step square root, 62-step
// divide) and writes one slot. A point word walks a row of MAX_CHAIN
// cells, through the product and output registers of each cell, the
// highest slot first; the row stalls while a result waits unaccepted;
// cells at or above chain_length pass the point unchanged. One word is in
// work at a time; a finished result waits in the output register.
module rigid_transform_chain_core #(
  parameter int MAX_CHAIN = 8
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [3:0]         cfg_wdata,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire               action,
  input  wire [2:0]         slot,
  input  wire signed [31:0] dir_x,
  input  wire signed [31:0] dir_y,
  input  wire signed [31:0] shift_x,
  input  wire signed [31:0] shift_y,
  input  wire signed [31:0] point_x,
  input  wire signed [31:0] point_y,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y
);

  rtc_pkg::top_state_t state, state_next;

  logic [3:0]         chain_length;
  logic [2:0]         slot_r;
  logic signed [31:0] tx_r, ty_r;
  logic               accept, en, norm_start, norm_done;
  logic signed [31:0] nux, nuy;
  rtc_pkg::xform_t    wdata;
  rtc_pkg::pt_t       entry;
  rtc_pkg::pt_t       link [MAX_CHAIN+1];

  assign accept = in_valid && in_ready;
  assign en     = !out_valid || out_ready;
  assign wdata  = '{ux: nux, uy: nuy, tx: tx_r, ty: ty_r};
  assign link[MAX_CHAIN] = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= '0;
    end else if (cfg_we) begin
      chain_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    norm_start = 1'b0;
    case (state)
      rtc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action == rtc_pkg::ACT_LOAD) begin
            norm_start = 1'b1;
            state_next = rtc_pkg::S_LOAD;
          end else begin
            state_next = rtc_pkg::S_POINT;
          end
        end
      end
      rtc_pkg::S_LOAD: begin
        if (norm_done) begin
          state_next = rtc_pkg::S_IDLE;
        end
      end
      rtc_pkg::S_POINT: begin
        if (link[0].valid && en) begin
          state_next = rtc_pkg::S_IDLE;
        end
      end
      default: state_next = rtc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r <= slot;
      tx_r   <= shift_x;
      ty_r   <= shift_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (accept && action == rtc_pkg::ACT_POINT) begin
      entry.valid <= 1'b1;
    end else if (en) begin
      entry.valid <= 1'b0;
    end
    if (accept) begin
      entry.x <= point_x;
      entry.y <= point_y;
    end
  end

  rtc_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .dir_x (dir_x),
    .dir_y (dir_y),
    .done  (norm_done),
    .ux    (nux),
    .uy    (nuy)
  );

  for (genvar i = 0; i < MAX_CHAIN; i++) begin : g_cell
    rtc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .we    (norm_done && int'(slot_r) == i),
      .wdata (wdata),
      .apply (int'(chain_length) > i),
      .pin   (link[i+1]),
      .pout  (link[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= link[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && link[0].valid) begin
      out_x <= link[0].x;
      out_y <= link[0].y;
    end
  end

endmodule
`default_nettype wire

### sv/rtc_checker.sv
`default_nettype none
module rtc_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               action,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [31:0] out_x,
  input wire signed [31:0] out_y
);

  // one word in work at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while busy");

  // a load never yields a result
  a_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == rtc_pkg::ACT_LOAD) |=> !$rose(out_valid))
    else $error("result after load");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)))
    else $error("result dropped or changed");

endmodule

bind rigid_transform_chain_core rtc_checker u_chk (.*);
`default_nettype wire

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = rtc_pkg::ACT_LOAD;
  logic [2:0] slot = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, shift_x = '0, shift_y = '0;
  logic signed [31:0] point_x = '0, point_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y;

  rigid_transform_chain_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .slot(slot),
    .dir_x(dir_x), .dir_y(dir_y), .shift_x(shift_x), .shift_y(shift_y),
    .point_x(point_x), .point_y(point_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y)
  );

  // predictor state
  logic signed [63:0] rot_c [NSLOTS];
  logic signed [63:0] rot_s [NSLOTS];
  logic signed [63:0] mov_x [NSLOTS];
  logic signed [63:0] mov_y [NSLOTS];
  bit                 slot_loaded [NSLOTS];
  int unsigned        chain_len = 0;

  logic signed [31:0] exp_x_q [$];
  logic signed [31:0] exp_y_q [$];

  int unsigned n_loads = 0, n_points = 0, n_results = 0;
  int unsigned n_mismatch = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  bit          idle_on = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b, rem;
    r = 0;
    rem = v;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic store_rotation(input int s, input logic signed [31:0] dx,
                                input logic signed [31:0] dy);
    logic [63:0] ax, ay, m, len;
    logic [127:0] qx, qy;
    ax = (dx < 0) ? 64'(-64'(dx)) : 64'(dx);
    ay = (dy < 0) ? 64'(-64'(dy)) : 64'(dy);
    if (ax == 0 && ay == 0) begin
      rot_c[s] = 0;
      rot_s[s] = 0;
      return;
    end
    m = (ax > ay) ? ax : ay;
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      ax = ax << 1;
      ay = ay << 1;
    end
    len = root64(ax * ax + ay * ay);
    qx = ((128'(ax) << 30) + 128'(len >> 1)) / 128'(len);
    qy = ((128'(ay) << 30) + 128'(len >> 1)) / 128'(len);
    rot_c[s] = (dx < 0) ? -$signed(64'(qx)) : $signed(64'(qx));
    rot_s[s] = (dy < 0) ? -$signed(64'(qy)) : $signed(64'(qy));
  endtask

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_point(input logic signed [31:0] px,
                               input logic signed [31:0] py);
    logic signed [63:0] x, y, nx, ny, acc;
    int n;
    x = px;
    y = py;
    n = (chain_len > NSLOTS) ? NSLOTS : chain_len;
    while (n > 0) begin
      n--;
      acc = rot_c[n] * x - rot_s[n] * y;
      nx = clamp32(((acc + (64'sd1 <<< 29)) >>> 30) + mov_x[n]);
      acc = rot_s[n] * x + rot_c[n] * y;
      ny = clamp32(((acc + (64'sd1 <<< 29)) >>> 30) + mov_y[n]);
      x = nx;
      y = ny;
    end
    exp_x_q = {exp_x_q, x[31:0]};
    exp_y_q = {exp_y_q, y[31:0]};
  endtask

  task automatic idle_gap();
    while (idle_on && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_word(input logic act, input logic [2:0] s,
                           input logic signed [31:0] dx, input logic signed [31:0] dy,
                           input logic signed [31:0] sx, input logic signed [31:0] sy,
                           input logic signed [31:0] px, input logic signed [31:0] py);
    idle_gap();
    in_valid <= 1'b1;
    action <= act;
    slot <= s;
    dir_x <= dx;
    dir_y <= dy;
    shift_x <= sx;
    shift_y <= sy;
    point_x <= px;
    point_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == rtc_pkg::ACT_LOAD) begin
      store_rotation(s, dx, dy);
      mov_x[s] = sx;
      mov_y[s] = sy;
      slot_loaded[s] = 1'b1;
      n_loads++;
    end else begin
      predict_point(px, py);
      n_points++;
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(255) - 128;
      3: return ($urandom_range(65535) - 32768) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_slot(input int s);
    send_word(rtc_pkg::ACT_LOAD, s[2:0], rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), $urandom, $urandom);
  endtask

  task automatic send_point();
    send_word(rtc_pkg::ACT_POINT, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
              rand_coord(), rand_coord());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_x_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_chain(input int unsigned n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    chain_len = n;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (exp_x_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word x=%h y=%h", out_x, out_y);
      end else begin
        if (out_x !== exp_x_q[0] || out_y !== exp_y_q[0]) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected x=%h y=%h, got x=%h y=%h",
                     exp_x_q[0], exp_y_q[0], out_x, out_y);
        end
        void'(exp_x_q.pop_front());
        void'(exp_y_q.pop_front());
      end
    end
  end

  // receiver with random idling and long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 14);
    end
  end

  task automatic test_directed();
    logic signed [31:0] ext [4];
    ext = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff};
    // zero direction, extreme directions and shifts
    send_word(rtc_pkg::ACT_LOAD, 3'd0, 0, 0, ext[0], ext[1], 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd1, ext[0], ext[0], ext[1], ext[0], 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd2, ext[1], ext[0], 0, 0, 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd3, 1, 0, ext[3], 1, 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd4, 0, -1, 32'sh0001_0000, 0, 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd5, ext[1], ext[1], ext[1], ext[1], 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd6, 32'sh0003_0000, 32'sh0004_0000, 0, ext[0], 0, 0);
    send_word(rtc_pkg::ACT_LOAD, 3'd7, -1, 1, ext[0], ext[0], 0, 0);
    set_chain(0);
    for (int i = 0; i < 4; i++)
      send_word(rtc_pkg::ACT_POINT, 3'd0, 0, 0, 0, 0, ext[i], ext[3 - i]);
    set_chain(8);
    for (int i = 0; i < 4; i++)
      send_word(rtc_pkg::ACT_POINT, 3'd0, 0, 0, 0, 0, ext[i], ext[i]);
    set_chain(15);
    send_word(rtc_pkg::ACT_POINT, 3'd0, 0, 0, 0, 0, 32'sh0001_0000, -32'sh0001_0000);
    set_chain(1);
    send_word(rtc_pkg::ACT_POINT, 3'd0, 0, 0, 0, 0, ext[1], ext[0]);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      set_chain((ph == 0) ? 8 : (ph == 1) ? 0 : $urandom_range(15));
      idle_on = (ph != 3);
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(99) < 20) load_slot($urandom_range(7));
        else send_point();
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    set_chain(8);
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_point();
    // sender waits for every result
    drain();
    for (int i = 0; i < 5; i++) send_point();
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      rot_c[i] = 0;
      rot_s[i] = 0;
      mov_x[i] = 0;
      mov_y[i] = 0;
      slot_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    $display("loads %0d, points %0d, results %0d over chain lengths 0 to 15",
             n_loads, n_points, n_results);
    $display("mismatches %0d", n_mismatch);
    if (n_mismatch == 0 && exp_x_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
